[hdl/grid_ray_march_threshold_stop_macros.svh]
// Assertion macros for the grid ray march block.
`ifndef GRID_RAY_MARCH_THRESHOLD_STOP_MACROS_SVH
`define GRID_RAY_MARCH_THRESHOLD_STOP_MACROS_SVH
`ifndef SYNTHESIS
`define GRMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GRMT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define GRMT_ASSERT(label, prop, msg)
`define GRMT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

[hdl/grmt_pkg.sv]
// Shared types and constants of the grid ray march block.
package grmt_pkg;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
  localparam logic [2:0] REG_CELL_EDGE  = 3'd2;
  localparam logic [2:0] REG_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_CELLS_WIDE = 3'd4;
  localparam logic [2:0] REG_CELLS_HIGH = 3'd5;

  localparam int NUM_W = 33;
  localparam int DEN_W = 31;
  localparam int ADDR_W = 16;

  typedef struct packed {
    logic              done;
    logic [NUM_W-1:0]  quo;
    logic [DEN_W-1:0]  rem;
  } div_res_t;
endpackage

[hdl/grmt_div.sv]
// Restoring divider, one quotient bit per cycle.
module grmt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [grmt_pkg::NUM_W-1:0]    num,
  input  logic [grmt_pkg::DEN_W-1:0]    den,
  output grmt_pkg::div_res_t            res
);
  logic                          busy_r;
  logic                          done_r;
  logic [5:0]                    cnt_r;
  logic [31:0]                   rem_r;
  logic [grmt_pkg::NUM_W-1:0]    quo_r;
  logic [grmt_pkg::DEN_W-1:0]    den_r;
  logic [31:0]                   sh;
  logic                          ge;

  assign sh = {rem_r[30:0], quo_r[grmt_pkg::NUM_W-1]};
  assign ge = sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(grmt_pkg::NUM_W - 1);
        rem_r  <= '0;
        quo_r  <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= ge ? (sh - {1'b0, den_r}) : sh;
        quo_r <= {quo_r[grmt_pkg::NUM_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign res.done = done_r;
  assign res.quo  = quo_r;
  assign res.rem  = rem_r[grmt_pkg::DEN_W-1:0];
endmodule

[hdl/grmt_ram.sv]
// Grid cell store, one write and one registered read port.
module grmt_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [grmt_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]                 wdata,
  input  logic [grmt_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]                 rdata
);
  logic [31:0] mem_r [0:(1<<grmt_pkg::ADDR_W)-1];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

[hdl/grid_ray_march_threshold_stop.sv]
// Grid ray march: DDA walk over a cell grid, stops at first cell below threshold.
// A write item stores one cell. A trace item takes two divisions (start cell
// in x and y, on one shared divider), set-up on one shared multiplier in states
// ST_M0 to ST_M7, then per visited cell a registered memory read and then a
// compare and step, then hands over the result and returns to idle. Set-up and
// walk are skipped when the start lies outside the grid, and the hand-over
// waits while an earlier result waits on out_stall. The walk visits at most
// cells_wide + cells_high + 1 cells. No item is taken while a trace runs.
`include "grid_ray_march_threshold_stop_macros.svh"
module grid_ray_march_threshold_stop #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [15:0]        in_cell_address,
  input  logic signed [31:0] in_cell_value,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [31:0] in_prior_hit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_hit_param,
  output logic               out_found,
  output logic [7:0]         out_stop_col,
  output logic [7:0]         out_stop_row
);
  localparam int CXW = $clog2(MAX_COLS) + 2;
  localparam int CYW = $clog2(MAX_ROWS) + 2;
  localparam int NXW = $clog2(MAX_COLS + 1);
  localparam int NYW = $clog2(MAX_ROWS + 1);
  localparam int SW  = $clog2(MAX_COLS + MAX_ROWS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIVX, ST_DIVY, ST_GRID, ST_M0, ST_M1, ST_M2, ST_M3,
    ST_M4, ST_M5, ST_M6, ST_M7, ST_RD, ST_CHK, ST_DONE
  } state_t;

  state_t state_r;

  logic signed [31:0] ox_r, oy_r, thr_r;
  logic [30:0]        edge_r;
  logic [8:0]         cw_r, ch_r;

  logic signed [31:0] sy_r, prior_r;
  logic signed [15:0] dx_r, dy_r;
  logic               negx_r;
  logic [32:0]        qx_r;
  logic [30:0]        rx_r;
  logic [CXW-1:0]     cx_r;
  logic [CYW-1:0]     cy_r;
  logic signed [34:0] kx_r, ky_r, ax_r, ay_r;
  logic signed [63:0] h_r, d_r, px_r, py_r;
  logic signed [51:0] prod_r;
  logic [15:0]        idx_r;
  logic [SW-1:0]      steps_r, cap_r;
  logic               res_found_r;
  logic signed [31:0] res_hit_r;

  logic               out_valid_r, out_found_r;
  logic signed [31:0] out_hit_r;
  logic [7:0]         out_col_r, out_row_r;

  logic [30:0]        e_c;
  logic [NXW-1:0]     nx_c;
  logic [NYW-1:0]     ny_c;
  logic signed [32:0] diffx_c, diffy_c;
  logic [32:0]        absx_c, absy_c;
  logic               div_start;
  logic [32:0]        div_num;
  grmt_pkg::div_res_t div_res;
  logic [31:0]        rdata;
  logic               mem_we;
  logic signed [34:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [16:0] adx_c, ady_c;
  logic               in_x_c, in_y_c;
  logic signed [34:0] kxn_c, kyn_c, axn_c, ayn_c;
  logic               go_x_c;
  logic [CXW-1:0]     cxn_c;
  logic [CYW-1:0]     cyn_c;
  logic               stay_c;
  logic signed [63:0] hs_c;
  logic signed [31:0] sat_c;
  logic               accept_c;

  assign e_c  = (edge_r == '0) ? 31'd1 : edge_r;
  assign nx_c = ({23'd0, cw_r} > 32'(MAX_COLS)) ? NXW'(MAX_COLS) : NXW'(cw_r);
  assign ny_c = ({23'd0, ch_r} > 32'(MAX_ROWS)) ? NYW'(MAX_ROWS) : NYW'(ch_r);

  assign diffx_c = 33'(in_start_x) - 33'(ox_r);
  assign diffy_c = 33'(sy_r) - 33'(oy_r);
  assign absx_c  = diffx_c[32] ? 33'(-diffx_c) : diffx_c;
  assign absy_c  = diffy_c[32] ? 33'(-diffy_c) : diffy_c;

  assign accept_c  = in_valid && !in_stall;
  assign mem_we    = accept_c && (in_opcode == grmt_pkg::OP_WRITE);
  assign div_start = (accept_c && (in_opcode == grmt_pkg::OP_TRACE)) ||
                     ((state_r == ST_DIVX) && div_res.done);
  assign div_num   = (state_r == ST_IDLE) ? absx_c : absy_c;

  grmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (e_c),
    .res   (div_res)
  );

  grmt_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_cell_address),
    .wdata (in_cell_value),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign adx_c = dx_r[15] ? 17'(-17'(dx_r)) : 17'(dx_r);
  assign ady_c = dy_r[15] ? 17'(-17'(dy_r)) : 17'(dy_r);

  // start-cell checks and corner offsets from the quotient and remainder
  assign in_x_c = (nx_c != '0) && (negx_r ? (qx_r == '0) : (qx_r < 33'(nx_c)));
  assign in_y_c = (ny_c != '0) &&
                  (diffy_c[32] ? (div_res.quo == '0) : (div_res.quo < 33'(ny_c)));
  assign kxn_c  = negx_r ? 35'(rx_r) : -35'(rx_r);
  assign kyn_c  = diffy_c[32] ? 35'(div_res.rem) : -35'(div_res.rem);
  assign axn_c  = (dx_r > 0) ? (35'(e_c) + kxn_c) : ((dx_r < 0) ? -kxn_c : '0);
  assign ayn_c  = (dy_r > 0) ? (35'(e_c) + kyn_c) : ((dy_r < 0) ? -kyn_c : '0);

  always_comb begin
    mul_a = kx_r;
    mul_b = 17'(dx_r);
    unique case (state_r)
      ST_M1:   begin mul_a = ky_r; mul_b = 17'(dy_r); end
      ST_M2:   begin mul_a = ax_r; mul_b = ady_c; end
      ST_M3:   begin mul_a = ay_r; mul_b = adx_c; end
      ST_M4:   begin mul_a = 35'(e_c); mul_b = adx_c; end
      ST_M5:   begin mul_a = 35'(e_c); mul_b = ady_c; end
      ST_M6:   begin mul_a = 35'(cy_r); mul_b = 17'(nx_c); end
      default: begin mul_a = kx_r; mul_b = 17'(dx_r); end
    endcase
  end

  assign go_x_c = (dx_r == '0) ? 1'b0 : ((dy_r == '0) ? 1'b1 : d_r[63]);
  assign cxn_c  = (dx_r < 0) ? (cx_r - CXW'(1)) : (cx_r + CXW'(1));
  assign cyn_c  = (dy_r < 0) ? (cy_r - CYW'(1)) : (cy_r + CYW'(1));
  assign stay_c = go_x_c ? (!cxn_c[CXW-1] && (cxn_c < CXW'(nx_c)))
                         : (!cyn_c[CYW-1] && (cyn_c < CYW'(ny_c)));

  assign hs_c  = h_r >>> 14;
  assign sat_c = (hs_c > 64'sd2147483647) ? 32'sh7fffffff :
                 ((hs_c < -64'sd2147483648) ? 32'sh80000000 : 32'(hs_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r   <= '0;
      oy_r   <= '0;
      edge_r <= 31'd65536;
      thr_r  <= '0;
      cw_r   <= 9'd256;
      ch_r   <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        grmt_pkg::REG_ORIGIN_X:   ox_r   <= cfg_wdata;
        grmt_pkg::REG_ORIGIN_Y:   oy_r   <= cfg_wdata;
        grmt_pkg::REG_CELL_EDGE:  edge_r <= cfg_wdata[30:0];
        grmt_pkg::REG_THRESHOLD:  thr_r  <= cfg_wdata;
        grmt_pkg::REG_CELLS_WIDE: cw_r   <= cfg_wdata[8:0];
        grmt_pkg::REG_CELLS_HIGH: ch_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      cap_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept_c && (in_opcode == grmt_pkg::OP_TRACE)) begin
            sy_r    <= in_start_y;
            dx_r    <= in_dir_x;
            dy_r    <= in_dir_y;
            prior_r <= in_prior_hit;
            negx_r  <= diffx_c[32];
            state_r <= ST_DIVX;
          end
        end
        ST_DIVX: begin
          if (div_res.done) begin
            qx_r    <= div_res.quo;
            rx_r    <= div_res.rem;
            state_r <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_res.done) begin
            res_found_r <= 1'b0;
            res_hit_r   <= prior_r;
            steps_r     <= '0;
            cap_r       <= SW'(nx_c) + SW'(ny_c);
            cx_r        <= negx_r ? '0 : CXW'(qx_r);
            cy_r        <= diffy_c[32] ? '0 : CYW'(div_res.quo);
            kx_r        <= kxn_c;
            ky_r        <= kyn_c;
            ax_r        <= axn_c;
            ay_r        <= ayn_c;
            state_r     <= (in_x_c && in_y_c) ? ST_M0 : ST_DONE;
          end
        end
        ST_M0: state_r <= ST_M1;
        ST_M1: begin h_r <= 64'(prod_r); state_r <= ST_M2; end
        ST_M2: begin h_r <= h_r + 64'(prod_r); state_r <= ST_M3; end
        ST_M3: begin d_r <= 64'(prod_r); state_r <= ST_M4; end
        ST_M4: begin d_r <= d_r - 64'(prod_r); state_r <= ST_M5; end
        ST_M5: begin px_r <= 64'(prod_r); state_r <= ST_M6; end
        ST_M6: begin py_r <= 64'(prod_r); state_r <= ST_M7; end
        ST_M7: begin
          idx_r   <= 16'(cx_r) + 16'(prod_r);
          state_r <= ST_RD;
        end
        ST_RD: state_r <= ST_CHK;
        ST_CHK: begin
          if ($signed(rdata) < thr_r) begin
            res_found_r <= 1'b1;
            res_hit_r   <= sat_c;
            state_r     <= ST_DONE;
          end else if (((dx_r == '0) && (dy_r == '0)) || (steps_r >= cap_r)) begin
            state_r <= ST_DONE;
          end else begin
            steps_r <= steps_r + SW'(1);
            if (go_x_c) begin
              cx_r  <= cxn_c;
              idx_r <= (dx_r < 0) ? (idx_r - 16'd1) : (idx_r + 16'd1);
              h_r   <= h_r + px_r;
              d_r   <= d_r + py_r;
            end else begin
              cy_r  <= cyn_c;
              idx_r <= (dy_r < 0) ? (idx_r - 16'(nx_c)) : (idx_r + 16'(nx_c));
              h_r   <= h_r + py_r;
              d_r   <= d_r - px_r;
            end
            state_r <= stay_c ? ST_RD : ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_hit_r   <= res_hit_r;
            out_found_r <= res_found_r;
            out_col_r   <= res_found_r ? 8'(cx_r) : 8'd0;
            out_row_r   <= res_found_r ? 8'(cy_r) : 8'd0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit_param = out_hit_r;
  assign out_found     = out_found_r;
  assign out_stop_col  = out_col_r;
  assign out_stop_row  = out_row_r;

  `GRMT_ASSERT(a_step_cap, steps_r <= cap_r, "walk ran past its step cap")
  `GRMT_ASSERT(a_chk_after_rd, (state_r == ST_CHK) |-> ($past(state_r) == ST_RD), "compare without read")
  `GRMT_ASSERT_NEXT(a_divx_to_divy, (state_r == ST_DIVX) && div_res.done, state_r == ST_DIVY, "y division not started")
endmodule
